### design/medt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mesh edge dedup table.
package medt_pkg;

    localparam int MAX_EDGES   = 1024;
    localparam int IDX_BITS    = $clog2(MAX_EDGES);
    localparam int CNT_BITS    = $clog2(MAX_EDGES + 1);
    localparam int NODE_BITS   = 16;
    localparam int VERTEX_BITS = 16;
    localparam int TAG_BITS    = 16;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_CELL = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [NODE_BITS-1:0] node_a;
        logic [NODE_BITS-1:0] node_b;
        logic [NODE_BITS-1:0] node_c;
        logic [NODE_BITS-1:0] node_d;
        logic [TAG_BITS-1:0]  phys_tag;
    } t_req;

    typedef struct packed {
        logic [IDX_BITS-1:0]    edge_index;
        logic [VERTEX_BITS-1:0] low_vertex;
        logic [VERTEX_BITS-1:0] high_vertex;
        logic [TAG_BITS-1:0]    stored_tag;
        logic                   is_new;
        logic                   table_full;
        logic                   last;
    } t_res;

    typedef struct packed {
        logic [VERTEX_BITS-1:0] lo;
        logic [VERTEX_BITS-1:0] hi;
        logic [TAG_BITS-1:0]    tag;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

### design/medt_store.sv
`timescale 1ns / 1ps
// Edge table memory: one write port, one registered read port.
module medt_store (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [medt_pkg::IDX_BITS-1:0] i_wr_addr,
    input  medt_pkg::t_entry              i_wr_data,
    input  logic                          i_rd_en,
    input  logic [medt_pkg::IDX_BITS-1:0] i_rd_addr,
    output medt_pkg::t_entry              o_rd_data
);

    medt_pkg::t_entry r_mem [medt_pkg::MAX_EDGES];
    medt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/medt_edge_form.sv
`timescale 1ns / 1ps
// Picks the node pair of one edge, converts to zero-based vertices and orders them.
module medt_edge_form (
    input  medt_pkg::t_req   i_req,
    input  logic [1:0]       i_side,
    output medt_pkg::t_entry o_edge
);

    logic [medt_pkg::NODE_BITS-1:0]   node_x;
    logic [medt_pkg::NODE_BITS-1:0]   node_y;
    logic [medt_pkg::VERTEX_BITS-1:0] vert_x;
    logic [medt_pkg::VERTEX_BITS-1:0] vert_y;

    always_comb begin
        case (i_side)
            2'd0: begin
                node_x = i_req.node_a;
                node_y = i_req.node_b;
            end
            2'd1: begin
                node_x = i_req.node_b;
                node_y = i_req.node_c;
            end
            2'd2: begin
                node_x = i_req.node_c;
                node_y = i_req.node_d;
            end
            default: begin
                node_x = i_req.node_d;
                node_y = i_req.node_a;
            end
        endcase
    end

    // Node zero wraps to the all-ones vertex, as the subtraction is modular.
    assign vert_x = medt_pkg::VERTEX_BITS'(node_x - medt_pkg::NODE_BITS'(1));
    assign vert_y = medt_pkg::VERTEX_BITS'(node_y - medt_pkg::NODE_BITS'(1));

    always_comb begin
        o_edge.lo  = (vert_x < vert_y) ? vert_x : vert_y;
        o_edge.hi  = (vert_x < vert_y) ? vert_y : vert_x;
        o_edge.tag = (i_req.cmd == medt_pkg::CMD_EDGE) ? i_req.phys_tag
                                                       : medt_pkg::TAG_BITS'(0);
    end

endmodule

### design/mesh_edge_dedup_table_top.sv
`timescale 1ns / 1ps
// Top level of the mesh edge dedup table: sequencer, scan compare and result register.
// An absent edge passes the setup state and then the scan of every stored entry; a hit
// ends the scan at its slot. A cell item runs its four sides back to back.
// The table scan, one stored entry per cycle through the single read port, sets the rate.
// busy stays high until the final result is registered; results cannot be stalled.
// Reset clears state, count, valid and pend; entries at or above the count are never read.
module mesh_edge_dedup_table_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  medt_pkg::t_req   i_req,
    output logic             o_valid,
    output medt_pkg::t_res   o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]                      r_state, n_state;
    logic [1:0]                      r_side, n_side;
    logic [medt_pkg::CNT_BITS-1:0]   r_count, n_count;
    logic [medt_pkg::CNT_BITS-1:0]   r_addr, n_addr;
    logic [medt_pkg::IDX_BITS-1:0]   r_pidx, n_pidx;
    logic                            r_pend, n_pend;
    logic                            r_valid, n_valid;
    medt_pkg::t_req                  r_req, n_req;
    medt_pkg::t_entry                r_edge, n_edge;
    medt_pkg::t_res                  r_res, n_res;

    medt_pkg::t_entry                form_edge;
    medt_pkg::t_entry                rd_data;
    logic                            rd_en;
    logic                            wr_en;
    logic                            hit;
    logic                            scan_done;
    logic                            last_side;

    medt_edge_form u_form (
        .i_req  (r_req),
        .i_side (r_side),
        .o_edge (form_edge)
    );

    medt_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[medt_pkg::IDX_BITS-1:0]),
        .i_wr_data (r_edge),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[medt_pkg::IDX_BITS-1:0]),
        .o_rd_data (rd_data)
    );

    assign busy      = (r_state != S_IDLE);
    assign rd_en     = (r_state == S_SCAN) && (r_addr != r_count);
    assign hit       = r_pend && (rd_data.lo == r_edge.lo) && (rd_data.hi == r_edge.hi);
    assign scan_done = !r_pend && (r_addr == r_count);
    assign last_side = (r_req.cmd == medt_pkg::CMD_EDGE) || (r_side == 2'd3);
    assign wr_en     = (r_state == S_SCAN) && !hit && scan_done &&
                       (r_count != medt_pkg::CNT_BITS'(medt_pkg::MAX_EDGES));

    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        n_count = r_count;
        n_addr  = r_addr;
        n_pidx  = r_pidx;
        n_pend  = r_pend;
        n_valid = 1'b0;
        n_req   = r_req;
        n_edge  = r_edge;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_side  = 2'd0;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_edge  = form_edge;
                n_addr  = '0;
                n_pend  = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hit || scan_done) begin
                    n_valid           = 1'b1;
                    n_res.low_vertex  = r_edge.lo;
                    n_res.high_vertex = r_edge.hi;
                    n_res.last        = last_side;
                    n_res.is_new      = 1'b0;
                    n_res.table_full  = 1'b0;
                    if (hit) begin
                        n_res.edge_index = r_pidx;
                        n_res.stored_tag = rd_data.tag;
                    end else if (wr_en) begin
                        n_res.edge_index = r_count[medt_pkg::IDX_BITS-1:0];
                        n_res.stored_tag = r_edge.tag;
                        n_res.is_new     = 1'b1;
                        n_count          = r_count + medt_pkg::CNT_BITS'(1);
                    end else begin
                        n_res.edge_index = '0;
                        n_res.stored_tag = '0;
                        n_res.table_full = 1'b1;
                    end
                    if (last_side) begin
                        n_state = S_IDLE;
                    end else begin
                        n_side  = r_side + 2'd1;
                        n_state = S_PREP;
                    end
                end else begin
                    // The read issued now is compared in the following cycle, once its data is registered.
                    n_pend = (r_addr != r_count);
                    n_pidx = r_addr[medt_pkg::IDX_BITS-1:0];
                    if (r_addr != r_count) begin
                        n_addr = r_addr + medt_pkg::CNT_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
        r_addr <= n_addr;
        r_pidx <= n_pidx;
        r_req  <= n_req;
        r_edge <= n_edge;
        r_res  <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### design/medt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the mesh edge dedup table, bound to the top level.
module medt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input medt_pkg::t_res o_res
);

    a_result_after_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    a_accept_goes_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_last_frees_block : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.last) |-> !busy)
        else $error("busy still high with the final result");

    a_full_fixed_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.table_full) |->
            (!o_res.is_new && o_res.edge_index == '0 && o_res.stored_tag == '0))
        else $error("table full result carries slot data");

    a_vertex_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.low_vertex <= o_res.high_vertex))
        else $error("edge vertices out of order");

endmodule

bind mesh_edge_dedup_table_top medt_checker u_medt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

### tb/sv/mesh_edge_dedup_table_check.sv
`timescale 1ns / 1ps
// Scoreboard for the mesh edge dedup table: predicts each edge lookup and checks every result.
module mesh_edge_dedup_table_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  medt_pkg::t_req  i_req,
    input  logic            i_valid,
    input  medt_pkg::t_res  i_res,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_edge_count,
    output int              o_checked,
    output int              o_new_count,
    output int              o_full_count
);

    // Shadow copy of the edge table, kept in slot order.
    medt_pkg::t_entry known_edges [medt_pkg::MAX_EDGES];
    int               stored_count = 0;
    medt_pkg::t_res   edge_reports_due [$];

    int fail_total = 0;
    int checked    = 0;
    int new_total  = 0;
    int full_total = 0;

    function automatic string show(medt_pkg::t_res r);
        return $sformatf("idx=%0d lo=%h hi=%h tag=%h new=%b full=%b last=%b",
                         r.edge_index, r.low_vertex, r.high_vertex, r.stored_tag,
                         r.is_new, r.table_full, r.last);
    endfunction

    task automatic flag_error(string why, string detail);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t ns: %s: %s", $time, why, detail);
        end
    endtask

    // Looks the edge up in slot order and appends it when absent and a slot is free.
    function automatic medt_pkg::t_res insert_edge(logic [medt_pkg::NODE_BITS-1:0] node_x,
                                                   logic [medt_pkg::NODE_BITS-1:0] node_y,
                                                   logic [medt_pkg::TAG_BITS-1:0] tag,
                                                   logic last_side);
        logic [medt_pkg::VERTEX_BITS-1:0] vx;
        logic [medt_pkg::VERTEX_BITS-1:0] vy;
        medt_pkg::t_res r;
        bit   hit;
        vx = medt_pkg::VERTEX_BITS'(node_x - medt_pkg::NODE_BITS'(1));
        vy = medt_pkg::VERTEX_BITS'(node_y - medt_pkg::NODE_BITS'(1));
        r = '0;
        r.low_vertex  = (vx < vy) ? vx : vy;
        r.high_vertex = (vx < vy) ? vy : vx;
        r.last = last_side;
        hit = 1'b0;
        for (int i = 0; i < stored_count && !hit; i++) begin
            if (known_edges[i].lo == r.low_vertex
                    && known_edges[i].hi == r.high_vertex) begin
                hit = 1'b1;
                r.edge_index = medt_pkg::IDX_BITS'(i);
                r.stored_tag = known_edges[i].tag;
            end
        end
        if (!hit) begin
            if (stored_count < medt_pkg::MAX_EDGES) begin
                known_edges[stored_count].lo  = r.low_vertex;
                known_edges[stored_count].hi  = r.high_vertex;
                known_edges[stored_count].tag = tag;
                r.edge_index = medt_pkg::IDX_BITS'(stored_count);
                r.stored_tag = tag;
                r.is_new = 1'b1;
                stored_count++;
            end else begin
                r.table_full = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        medt_pkg::t_res want;
        logic [medt_pkg::NODE_BITS-1:0] corner [4];
        if (!i_rst_n) begin
            stored_count = 0;
            edge_reports_due.delete();
        end else begin
            if (i_valid === 1'b1) begin
                checked++;
                if (edge_reports_due.size() == 0) begin
                    flag_error("result with nothing expected", show(i_res));
                end else begin
                    want = edge_reports_due.pop_front();
                    if (i_res.edge_index !== want.edge_index
                            || i_res.low_vertex !== want.low_vertex
                            || i_res.high_vertex !== want.high_vertex
                            || i_res.stored_tag !== want.stored_tag
                            || i_res.is_new !== want.is_new
                            || i_res.table_full !== want.table_full
                            || i_res.last !== want.last) begin
                        flag_error("result mismatch",
                                   $sformatf("expected %s, got %s", show(want), show(i_res)));
                    end
                    if (want.is_new) begin
                        new_total++;
                    end
                    if (want.table_full) begin
                        full_total++;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                if (i_req.cmd == medt_pkg::CMD_EDGE) begin
                    edge_reports_due.push_back(
                        insert_edge(i_req.node_a, i_req.node_b, i_req.phys_tag, 1'b1));
                end else begin
                    corner[0] = i_req.node_a;
                    corner[1] = i_req.node_b;
                    corner[2] = i_req.node_c;
                    corner[3] = i_req.node_d;
                    // Side k joins corner k to the next corner, wrapping after the fourth.
                    for (int side = 0; side < 4; side++) begin
                        edge_reports_due.push_back(insert_edge(corner[side],
                            corner[(side + 1) % 4], '0, side == 3));
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= edge_reports_due.size();
        o_edge_count <= stored_count;
        o_checked    <= checked;
        o_new_count  <= new_total;
        o_full_count <= full_total;
    end

endmodule

### tb/sv/mesh_edge_dedup_table_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the mesh edge dedup table: request stimulus, watchdog and verdict.
module mesh_edge_dedup_table_top_test;

    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 4200;
    localparam int GRID_W       = 12;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_valid;
    medt_pkg::t_req i_req;
    medt_pkg::t_res o_res;

    int fail_count;
    int pending;
    int edge_count;
    int checked;
    int new_count;
    int full_count;

    int quiet_cycles = 0;
    int edge_items   = 0;
    int cell_items   = 0;
    int gap_pct      = 0;

    mesh_edge_dedup_table_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    mesh_edge_dedup_table_check edge_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_edge_count (edge_count),
        .o_checked    (checked),
        .o_new_count  (new_count),
        .o_full_count (full_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Reset, any accepted request or any result resets the count of quiet cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles.", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic medt_pkg::t_req edge_req(logic [15:0] a, logic [15:0] b,
                                                logic [15:0] tag);
        medt_pkg::t_req r;
        r.cmd      = medt_pkg::CMD_EDGE;
        r.node_a   = a;
        r.node_b   = b;
        r.node_c   = 16'($urandom);
        r.node_d   = 16'($urandom);
        r.phys_tag = tag;
        return r;
    endfunction

    function automatic medt_pkg::t_req cell_req(logic [15:0] a, logic [15:0] b,
                                                logic [15:0] c, logic [15:0] d);
        medt_pkg::t_req r;
        r.cmd      = medt_pkg::CMD_CELL;
        r.node_a   = a;
        r.node_b   = b;
        r.node_c   = c;
        r.node_d   = d;
        r.phys_tag = 16'($urandom);
        return r;
    endfunction

    // A quad of a small structured grid, so neighbouring cells share sides.
    function automatic medt_pkg::t_req grid_cell();
        logic [15:0] corner [4];
        int row;
        int col;
        int rot;
        int step;
        row  = $urandom_range(GRID_W - 2);
        col  = $urandom_range(GRID_W - 2);
        rot  = $urandom_range(3);
        step = ($urandom_range(1) == 1) ? 3 : 1;
        corner[0] = 16'(row * GRID_W + col + 1);
        corner[1] = corner[0] + 16'd1;
        corner[2] = corner[0] + 16'(GRID_W + 1);
        corner[3] = corner[0] + 16'(GRID_W);
        return cell_req(corner[rot], corner[(rot + step) % 4], corner[(rot + 2) % 4],
                        corner[(rot + 2 * step) % 4 == (rot + 2) % 4 ?
                               (rot + 3 * step) % 4 : (rot + 2 * step) % 4]);
    endfunction

    // A boundary edge along a grid line, which often repeats a cell side.
    function automatic medt_pkg::t_req grid_edge();
        logic [15:0] n;
        logic [15:0] m;
        n = 16'($urandom_range(GRID_W - 2) * GRID_W + $urandom_range(GRID_W - 2) + 1);
        m = n + (($urandom_range(1) == 1) ? 16'd1 : 16'(GRID_W));
        if ($urandom_range(1) == 1) begin
            return edge_req(m, n, 16'($urandom));
        end
        return edge_req(n, m, 16'($urandom));
    endfunction

    function automatic medt_pkg::t_req random_item();
        medt_pkg::t_req r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            r = grid_cell();
        end else if (pick < 65) begin
            r = grid_edge();
        end else if (pick < 80) begin
            r = edge_req(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                         16'($urandom));
        end else begin
            r.cmd      = ($urandom_range(1) == 1) ? medt_pkg::CMD_CELL : medt_pkg::CMD_EDGE;
            r.node_a   = 16'($urandom);
            r.node_b   = 16'($urandom);
            r.node_c   = 16'($urandom);
            r.node_d   = 16'($urandom);
            r.phys_tag = 16'($urandom);
        end
        return r;
    endfunction

    task automatic send_request(medt_pkg::t_req r);
        int gap;
        if ($urandom_range(99) < gap_pct) begin
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        if (r.cmd == medt_pkg::CMD_EDGE) begin
            edge_items++;
        end else begin
            cell_items++;
        end
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    // The pending count from the scoreboard is registered, so it trails an acceptance.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        medt_pkg::t_req r;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests: duplicates in both orders, wrap of node zero, the top node
        // number, degenerate edges, a cell with a repeated side and ignored fields.
        send_request(edge_req(16'd1, 16'd2, 16'hFFFF));
        send_request(edge_req(16'd2, 16'd1, 16'h0005));
        send_request(edge_req(16'd0, 16'hFFFF, 16'h0001));
        send_request(edge_req(16'hFFFF, 16'hFFFF, 16'h8000));
        send_request(edge_req(16'd0, 16'd0, 16'h1234));
        send_request(edge_req(16'd1, 16'd1, 16'h0000));
        send_request(cell_req(16'd1, 16'd2, 16'd3, 16'd4));
        send_request(cell_req(16'd4, 16'd3, 16'd2, 16'd1));
        send_request(cell_req(16'd5, 16'd6, 16'd5, 16'd6));
        send_request(cell_req(16'd7, 16'd7, 16'd7, 16'd7));
        send_request(cell_req(16'd0, 16'hFFFF, 16'd1, 16'd0));
        r = edge_req(16'd3, 16'd2, 16'h00AA);
        r.node_c = 16'hFFFF;
        r.node_d = 16'hFFFF;
        send_request(r);
        send_request(edge_req(16'h8000, 16'h7FFF, 16'h5555));
        r = cell_req(16'hAAAA, 16'h5555, 16'hFFFF, 16'd1);
        r.phys_tag = 16'hFFFF;
        send_request(r);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 9 : (phase == 1) ? 59 : 0;
            repeat (42) send_request(random_item());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d boundary-edge and %0d quad-cell requests, the table filled to %0d.",
                 edge_items, cell_items, edge_count);
        $display("Checked %0d edge results: %0d inserted, %0d refused on a full table.",
                 checked, new_count, full_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
